/* rtl/fcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared constants and types for the frame checksum command parser.
// ----------------------------------------------------------------------------
package fcp_pkg;

    localparam logic [15:0] HEADER_MAGIC   = 16'hCCDD;
    localparam logic [7:0]  TYPE_HEARTBEAT = 8'h01;
    localparam logic [7:0]  TYPE_COMMAND   = 8'h02;
    localparam logic [15:0] MIN_LEN_ANY    = 16'd6;
    localparam logic [15:0] MIN_LEN_TYPED  = 16'd9;
    localparam logic [15:0] MAX_FRAME_LEN  = 16'd2048;

    // byte positions inside a frame
    localparam logic [15:0] POS_HDR_HI  = 16'd0;
    localparam logic [15:0] POS_HDR_LO  = 16'd1;
    localparam logic [15:0] POS_LEN_HI  = 16'd2;
    localparam logic [15:0] POS_LEN_LO  = 16'd3;
    localparam logic [15:0] POS_TYPE    = 16'd4;
    localparam logic [15:0] POS_PAY0    = 16'd5;
    localparam logic [15:0] POS_PAY1    = 16'd6;
    localparam logic [15:0] POS_PAY2    = 16'd7;

    // frame status codes
    localparam logic [2:0] ST_HEARTBEAT    = 3'd0;
    localparam logic [2:0] ST_CMD_STORED   = 3'd1;
    localparam logic [2:0] ST_CMD_IGNORED  = 3'd2;
    localparam logic [2:0] ST_OTHER_TYPE   = 3'd3;
    localparam logic [2:0] ST_BAD_HEADER   = 3'd4;
    localparam logic [2:0] ST_BAD_CHECKSUM = 3'd5;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd6;

    // one classified frame event; a command frame travels as ST_CMD_STORED
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pay0;
        logic [7:0] pay1;
        logic [7:0] pay2;
    } fcp_event_t;

endpackage

/* rtl/fcp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_in_if
// Byte stream channel into the parser.
// ----------------------------------------------------------------------------
interface fcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

/* rtl/fcp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_out_if
// Frame status channel out of the parser.
// ----------------------------------------------------------------------------
interface fcp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_status;
    logic [7:0] heartbeat_count;
    logic [7:0] main_version;
    logic [7:0] minor_version;
    logic [1:0] run_service_cmd;
    logic [1:0] door_cmd;
    logic [1:0] cc_cmd;
    logic [7:0] cmd_byte_one;
    logic [7:0] cmd_byte_two;

    modport source (
        output valid, output frame_status, output heartbeat_count,
        output main_version, output minor_version, output run_service_cmd,
        output door_cmd, output cc_cmd, output cmd_byte_one, output cmd_byte_two,
        input  ready
    );
    modport sink (
        input  valid, input frame_status, input heartbeat_count,
        input  main_version, input minor_version, input run_service_cmd,
        input  door_cmd, input cc_cmd, input cmd_byte_one, input cmd_byte_two,
        output ready
    );
endinterface

/* rtl/fcp_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_cfg_if
// Configuration write channel carrying the local mode bit.
// ----------------------------------------------------------------------------
interface fcp_cfg_if;
    logic valid;
    logic ready;
    logic local_mode;

    modport source (output valid, output local_mode, input ready);
    modport sink   (input valid, input local_mode, output ready);
endinterface

/* rtl/fcp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_front
// Byte parser: tracks position, header, length, type and checksum, and
// pushes one classified event per finished or rejected frame.
// ----------------------------------------------------------------------------
module fcp_front (
    input  logic               clk,
    input  logic               rst_n,
    fcp_in_if.sink             rx,
    output logic               push_valid,
    output fcp_pkg::fcp_event_t push_event,
    input  logic               push_ready
);
    import fcp_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic        active_reg, active_next;
    logic [7:0]  hdr_hi_reg, hdr_hi_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  pay0_reg, pay0_next;
    logic [7:0]  pay1_reg, pay1_next;
    logic [7:0]  pay2_reg, pay2_next;

    logic        xfer;
    logic        act;
    logic [15:0] pos;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] len_full;
    logic [2:0]  status;

    assign rx.ready = push_ready;
    assign xfer     = rx.valid && push_ready;
    assign b        = rx.data_byte;

    always_comb
    begin
        pos_next    = pos_reg;
        active_next = active_reg;
        hdr_hi_next = hdr_hi_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        sum_next    = sum_reg;
        pay0_next   = pay0_reg;
        pay1_next   = pay1_reg;
        pay2_next   = pay2_reg;
        push_valid  = 1'b0;
        status      = ST_OTHER_TYPE;

        act      = active_reg || rx.frame_start;
        pos      = rx.frame_start ? 16'd0 : pos_reg;
        sum      = rx.frame_start ? 8'd0 : sum_reg;
        len_full = {len_reg[15:8], b};

        if (xfer && act)
        begin
            active_next = 1'b1;
            pos_next    = pos + 16'd1;
            sum_next    = sum;
            if (pos >= POS_PAY0 && pos == len_reg - 16'd1)
            begin
                // checksum byte closes the frame
                active_next = 1'b0;
                push_valid  = 1'b1;
                if (sum != b)
                    status = ST_BAD_CHECKSUM;
                else if (type_reg == TYPE_HEARTBEAT)
                    status = ST_HEARTBEAT;
                else if (type_reg == TYPE_COMMAND)
                    status = ST_CMD_STORED;
                else
                    status = ST_OTHER_TYPE;
            end
            else
            begin
                sum_next = sum + b;
                unique case (pos)
                    POS_HDR_HI: hdr_hi_next = b;
                    POS_HDR_LO:
                    begin
                        if ({hdr_hi_reg, b} != HEADER_MAGIC)
                        begin
                            active_next = 1'b0;
                            push_valid  = 1'b1;
                            status      = ST_BAD_HEADER;
                        end
                    end
                    POS_LEN_HI: len_next = {b, 8'h00};
                    POS_LEN_LO:
                    begin
                        len_next = len_full;
                        if (len_full < MIN_LEN_ANY || len_full > MAX_FRAME_LEN)
                        begin
                            active_next = 1'b0;
                            push_valid  = 1'b1;
                            status      = ST_BAD_LENGTH;
                        end
                    end
                    POS_TYPE:
                    begin
                        type_next = b;
                        if ((b == TYPE_HEARTBEAT || b == TYPE_COMMAND)
                            && len_reg < MIN_LEN_TYPED)
                        begin
                            active_next = 1'b0;
                            push_valid  = 1'b1;
                            status      = ST_BAD_LENGTH;
                        end
                    end
                    POS_PAY0: pay0_next = b;
                    POS_PAY1: pay1_next = b;
                    POS_PAY2: pay2_next = b;
                    default:  ;
                endcase
            end
        end
    end

    assign push_event.status = status;
    assign push_event.pay0   = pay0_reg;
    assign push_event.pay1   = pay1_reg;
    assign push_event.pay2   = pay2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 16'd0;
            active_reg <= 1'b0;
            hdr_hi_reg <= 8'd0;
            len_reg    <= 16'd0;
            type_reg   <= 8'd0;
            sum_reg    <= 8'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
            hdr_hi_reg <= hdr_hi_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay0_reg <= pay0_next;
        pay1_reg <= pay1_next;
        pay2_reg <= pay2_next;
    end

endmodule

/* rtl/fcp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_queue
// Two-entry event queue between the parser and the executor.
// ----------------------------------------------------------------------------
module fcp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  fcp_pkg::fcp_event_t push_event,
    output logic                push_ready,
    output logic                pop_valid,
    output fcp_pkg::fcp_event_t pop_event,
    input  logic                pop_ready
);
    import fcp_pkg::*;

    fcp_event_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_event  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_event;
    end

endmodule

/* rtl/fcp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_back
// Executor: applies frame events to the host status and command registers
// and presents one status transfer per event.
// ----------------------------------------------------------------------------
module fcp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  fcp_pkg::fcp_event_t pop_event,
    output logic                pop_ready,
    fcp_cfg_if.sink             cfg,
    fcp_out_if.source           status
);
    import fcp_pkg::*;

    logic       local_mode_reg;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_status_reg, out_status_next;
    logic [7:0] hb_reg, hb_next;
    logic [7:0] main_reg, main_next;
    logic [7:0] minor_reg, minor_next;
    logic [1:0] run_reg, run_next;
    logic [1:0] door_reg, door_next;
    logic [1:0] cc_reg, cc_next;
    logic [7:0] cmd1_reg, cmd1_next;
    logic [7:0] cmd2_reg, cmd2_next;
    logic       do_pop;

    assign cfg.ready = 1'b1;
    // stored registers only change on a pop, so they stay steady under a stall
    assign pop_ready = !out_valid_reg || status.ready;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        hb_next         = hb_reg;
        main_next       = main_reg;
        minor_next      = minor_reg;
        run_next        = run_reg;
        door_next       = door_reg;
        cc_next         = cc_reg;
        cmd1_next       = cmd1_reg;
        cmd2_next       = cmd2_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !status.ready;

        if (do_pop)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pop_event.status;
            if (pop_event.status == ST_HEARTBEAT)
            begin
                hb_next    = pop_event.pay0;
                main_next  = pop_event.pay1;
                minor_next = pop_event.pay2;
            end
            else if (pop_event.status == ST_CMD_STORED)
            begin
                if (local_mode_reg)
                begin
                    run_next  = pop_event.pay0[7:6];
                    door_next = pop_event.pay0[3:2];
                    cc_next   = pop_event.pay0[1:0];
                    cmd1_next = pop_event.pay1;
                    cmd2_next = pop_event.pay2;
                end
                else
                    out_status_next = ST_CMD_IGNORED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mode_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_HEARTBEAT;
            hb_reg         <= 8'd0;
            main_reg       <= 8'd0;
            minor_reg      <= 8'd0;
            run_reg        <= 2'd0;
            door_reg       <= 2'd0;
            cc_reg         <= 2'd0;
            cmd1_reg       <= 8'd0;
            cmd2_reg       <= 8'd0;
        end
        else
        begin
            if (cfg.valid)
                local_mode_reg <= cfg.local_mode;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            hb_reg         <= hb_next;
            main_reg       <= main_next;
            minor_reg      <= minor_next;
            run_reg        <= run_next;
            door_reg       <= door_next;
            cc_reg         <= cc_next;
            cmd1_reg       <= cmd1_next;
            cmd2_reg       <= cmd2_next;
        end
    end

    assign status.valid           = out_valid_reg;
    assign status.frame_status    = out_status_reg;
    assign status.heartbeat_count = hb_reg;
    assign status.main_version    = main_reg;
    assign status.minor_version   = minor_reg;
    assign status.run_service_cmd = run_reg;
    assign status.door_cmd        = door_reg;
    assign status.cc_cmd          = cc_reg;
    assign status.cmd_byte_one    = cmd1_reg;
    assign status.cmd_byte_two    = cmd2_reg;

endmodule

/* rtl/frame_checksum_command_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checksum_command_parser_unit
// Datagram parser with header, length and checksum checks that stores host
// heartbeat and command frames and reports one status per frame.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer
//  rx       in   data_byte, frame_start                    valid && ready
//  status   out  frame_status + stored host/command regs   valid && ready
//  cfg      in   local_mode                                valid && ready
//
//  One byte per cycle sustained; the parser and the running sum each take
//  one byte per clock. Each frame event is registered in the queue, then in the output stage.
//  A two-entry event queue lets the parser keep taking bytes while a status
//  waits on the output; rx stalls only when that queue is full.
//  Reset (rst_n low, asynchronous) idles the parser, clears stored registers
//  and sets local mode.
// ----------------------------------------------------------------------------
module frame_checksum_command_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    fcp_in_if.sink    rx,
    fcp_out_if.source status,
    fcp_cfg_if.sink   cfg
);
    import fcp_pkg::*;

    logic       push_valid;
    fcp_event_t push_event;
    logic       push_ready;
    logic       pop_valid;
    fcp_event_t pop_event;
    logic       pop_ready;

    fcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_event (push_event),
        .push_ready (push_ready)
    );

    fcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_event (push_event),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_event  (pop_event),
        .pop_ready  (pop_ready)
    );

    fcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_event (pop_event),
        .pop_ready (pop_ready),
        .cfg       (cfg),
        .status    (status)
    );

endmodule
